### sv/dssm_pkg.sv
// Shared types, codes and defaults for the dual stack shared memory block.
`default_nettype none

package dssm_pkg;

    localparam int DSSM_SLOTS = 128;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        MODE_PUSH_LOWER = 2'd0,
        MODE_POP_LOWER  = 2'd1,
        MODE_PUSH_UPPER = 2'd2,
        MODE_POP_UPPER  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_READ,
        CS_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic exec;     // take the request word, update pointers, touch the RAM
        logic capture;  // load the result register from the RAM read data
    } dssm_cmd_t;

endpackage

`default_nettype wire

### sv/dual_stack_shared_memory.sv
// Top level: two LIFO stacks sharing one RAM, stream request and result channels.
//
// Usage
//   Requests come in on the s_ channel, one word per request. tuser carries the
//   mode (push lower, pop lower, push upper, pop upper), tdata the value to push.
//   Every request yields exactly one result word on the m_ channel: tuser is the
//   status (done, full, empty), tdata holds the popped value (zero unless a pop
//   succeeded) and both stack counts after the request.
//   The lower stack grows up from slot 0, the upper one down from slot SLOTS-1;
//   a push is refused once both together hold SLOTS elements.
// Timing
//   A request accepted at an edge updates the pointers and starts the RAM access
//   at that edge; the controller then enters the read state, where the
//   registered read data is loaded into the result register, and after it the
//   hold state, where the result word is offered until the handshake. One
//   request is in flight at a time, so the block takes a new word only after
//   the result handshake of the last one.
// Reset and stall
//   rst_n clears both stack counts and the controller; RAM contents stay
//   undefined and are never read before being written. While the receiver
//   stalls, the result word is held stable and s_tready stays low.
`default_nettype none

module dual_stack_shared_memory import dssm_pkg::*; #(
    parameter int SLOTS = DSSM_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // [31:0] popped_value, [39:32] lower_count,
                                        // [47:40] upper_count
    output logic      [1:0]  m_tuser    // [1:0] status
);

    dssm_cmd_t          cmd;
    logic [DATA_W-1:0]  popped_value;
    logic [COUNT_W-1:0] lower_count;
    logic [COUNT_W-1:0] upper_count;

    // handshake and sequencing
    dssm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // pointers, RAM and result register
    dssm_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (s_tuser),
        .push_value   (s_tdata),
        .status       (m_tuser),
        .popped_value (popped_value),
        .lower_count  (lower_count),
        .upper_count  (upper_count)
    );

    assign m_tdata = {upper_count, lower_count, popped_value};

    // one request in flight: never ready for input while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && s_tready))
        else $error("input ready while result pending");

    // result is offered once the RAM read data has been captured
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("result not valid two cycles after request");

    // refused requests never carry data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STAT_FULL || m_tuser == STAT_EMPTY))
            |-> (m_tdata[31:0] == '0))
        else $error("refused request returned nonzero data");

endmodule

`default_nettype wire

### sv/dssm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module dssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

### sv/dssm_datapath.sv
// Datapath: stack pointers, shared RAM and result register.
`default_nettype none

module dssm_datapath import dssm_pkg::*; #(
    parameter int SLOTS = DSSM_SLOTS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dssm_cmd_t           cmd,
    input  wire logic [1:0]          mode,
    input  wire logic [DATA_W-1:0]   push_value,
    output logic      [1:0]          status,
    output logic      [DATA_W-1:0]   popped_value,
    output logic      [COUNT_W-1:0]  lower_count,
    output logic      [COUNT_W-1:0]  upper_count
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW:0] SLOTS_W = (CW+1)'(SLOTS);

    logic [CW-1:0]      lower_cnt_reg, lower_cnt_next;
    logic [CW-1:0]      upper_cnt_reg, upper_cnt_next;
    status_t            stat_reg, stat_next;
    logic               pop_ok_reg, pop_ok_next;
    logic [DATA_W-1:0]  popped_reg;
    logic [COUNT_W-1:0] lower_out_reg, upper_out_reg;

    logic [CW:0]        held;
    logic               full;
    logic [CW:0]        up_push_idx, up_pop_idx, lo_pop_idx;
    logic [AW-1:0]      ram_addr;
    logic               ram_we, ram_re;
    logic [DATA_W-1:0]  ram_rdata;
    logic [CW+COUNT_W-1:0] lower_ext, upper_ext;

    assign held        = {1'b0, lower_cnt_reg} + {1'b0, upper_cnt_reg};
    assign full        = (held >= SLOTS_W);
    assign up_push_idx = SLOTS_W - 1'b1 - {1'b0, upper_cnt_reg};
    assign up_pop_idx  = SLOTS_W - {1'b0, upper_cnt_reg};
    assign lo_pop_idx  = {1'b0, lower_cnt_reg} - 1'b1;

    always_comb
    begin
        lower_cnt_next = lower_cnt_reg;
        upper_cnt_next = upper_cnt_reg;
        stat_next      = stat_reg;
        pop_ok_next    = pop_ok_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = lower_cnt_reg[AW-1:0];
        if (cmd.exec)
        begin
            stat_next   = STAT_DONE;
            pop_ok_next = 1'b0;
            case (mode_t'(mode))
                MODE_PUSH_LOWER:
                begin
                    ram_addr = lower_cnt_reg[AW-1:0];
                    if (full)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        lower_cnt_next = lower_cnt_reg + 1'b1;
                    end
                end
                MODE_POP_LOWER:
                begin
                    ram_addr = lo_pop_idx[AW-1:0];
                    if (lower_cnt_reg == '0)
                    begin
                        stat_next = STAT_EMPTY;
                    end
                    else
                    begin
                        ram_re         = 1'b1;
                        pop_ok_next    = 1'b1;
                        lower_cnt_next = lower_cnt_reg - 1'b1;
                    end
                end
                MODE_PUSH_UPPER:
                begin
                    ram_addr = up_push_idx[AW-1:0];
                    if (full)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        upper_cnt_next = upper_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    ram_addr = up_pop_idx[AW-1:0];
                    if (upper_cnt_reg == '0)
                    begin
                        stat_next = STAT_EMPTY;
                    end
                    else
                    begin
                        ram_re         = 1'b1;
                        pop_ok_next    = 1'b1;
                        upper_cnt_next = upper_cnt_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    dssm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (push_value),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_cnt_reg <= '0;
            upper_cnt_reg <= '0;
            pop_ok_reg    <= 1'b0;
            stat_reg      <= STAT_DONE;
        end
        else
        begin
            lower_cnt_reg <= lower_cnt_next;
            upper_cnt_reg <= upper_cnt_next;
            pop_ok_reg    <= pop_ok_next;
            stat_reg      <= stat_next;
        end
    end

    // counts are reported modulo 256
    assign lower_ext = {{COUNT_W{1'b0}}, lower_cnt_reg};
    assign upper_ext = {{COUNT_W{1'b0}}, upper_cnt_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            popped_reg    <= pop_ok_reg ? ram_rdata : '0;
            lower_out_reg <= lower_ext[COUNT_W-1:0];
            upper_out_reg <= upper_ext[COUNT_W-1:0];
        end
    end

    assign status       = stat_reg;
    assign popped_value = popped_reg;
    assign lower_count  = lower_out_reg;
    assign upper_count  = upper_out_reg;

endmodule

`default_nettype wire

### sv/dssm_ctrl.sv
// Controller FSM: request handshake, RAM read wait and result hold.
`default_nettype none

module dssm_ctrl import dssm_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output dssm_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = CS_READ;
                end
            end
            CS_READ:
            begin
                state_next = CS_HOLD;
            end
            CS_HOLD:
            begin
                if (m_tready)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                s_tready = 1'b1;
                cmd.exec = s_tvalid;
            end
            CS_READ:
            begin
                cmd.capture = 1'b1;
            end
            CS_HOLD:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for dual_stack_shared_memory: random push/pop traffic on both stacks, self-checking.
module tb;
    import dssm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 300;     // request count that triggers the long sink stall
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        mode_t       mode;
        logic [31:0] value;
    } request_t;

    typedef struct {
        status_t     status;
        logic [31:0] popped;
        logic [7:0]  lower;
        logic [7:0]  upper;
    } outcome_t;

    // traffic profile of one stretch of random requests
    typedef enum {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX
    } seg_kind_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] push_value
    logic [1:0]  s_tuser  = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [31:0] popped_value, [39:32] lower_count,
                                  // [47:40] upper_count
    logic [1:0]  m_tuser;         // [1:0] status

    request_t request_q[$];       // words still to be offered
    outcome_t outcome_q[$];       // predicted result words, oldest first

    // predictor state: own copy of the shared RAM and both stack depths
    logic [31:0] shadow_ram [DSSM_SLOTS];
    int          lower_held = 0;
    int          upper_held = 0;

    int total_words   = 0;
    int words_offered = 0;
    int words_in      = 0;
    int words_out     = 0;
    int errors        = 0;
    int cycles        = 0;

    // coverage tallies for the summary
    int n_push_done = 0;
    int n_pop_done  = 0;
    int n_full      = 0;
    int n_empty     = 0;
    int peak_held   = 0;

    int hold_left = 0;
    bit hold_done = 1'b0;

    dual_stack_shared_memory dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Two stacks in one array: lower grows up from slot 0, upper down from the top.
    // Full is decided on the combined depth, never on slot contents.
    function automatic outcome_t stack_model_step(mode_t m, logic [31:0] v);
        outcome_t r;
        int       held;
        r.status = STAT_DONE;
        r.popped = '0;
        held = lower_held + upper_held;
        case (m)
            MODE_PUSH_LOWER:
                if (held >= DSSM_SLOTS)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_ram[lower_held] = v;
                    lower_held++;
                end
            MODE_POP_LOWER:
                if (lower_held == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    lower_held--;
                    r.popped = shadow_ram[lower_held];
                end
            MODE_PUSH_UPPER:
                if (held >= DSSM_SLOTS)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_ram[DSSM_SLOTS - 1 - upper_held] = v;
                    upper_held++;
                end
            default:
                if (upper_held == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    upper_held--;
                    r.popped = shadow_ram[DSSM_SLOTS - 1 - upper_held];
                end
        endcase
        r.lower = lower_held[7:0];
        r.upper = upper_held[7:0];

        if (r.status == STAT_FULL)
            n_full++;
        else if (r.status == STAT_EMPTY)
            n_empty++;
        else if (m == MODE_PUSH_LOWER || m == MODE_PUSH_UPPER)
            n_push_done++;
        else
            n_pop_done++;
        if (lower_held + upper_held > peak_held)
            peak_held = lower_held + upper_held;
        return r;
    endfunction

    // data mix leans on the corner values: zero, all ones, both signed extremes
    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // idle rates per third of the run: source 24/76/0, sink 76/24/0
    function automatic int src_idle_pct();
        case ((words_in * 3) / (total_words > 0 ? total_words : 1))
            0:       return 24;
            1:       return 76;
            default: return 0;
        endcase
    endfunction

    function automatic int sink_idle_pct();
        case ((words_in * 3) / (total_words > 0 ? total_words : 1))
            0:       return 76;
            1:       return 24;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch: result %0d field %s got %h want %h", words_out, field, got, want);
        errors++;
    endtask

    // Source side: a word once offered is held until the block takes it.
    always @(negedge clk)
    begin : source_drive
        request_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!(s_tvalid && words_in < words_offered))
        begin
            if (request_q.size() > 0 && $urandom_range(99) >= src_idle_pct())
            begin
                nxt = request_q.pop_front();
                s_tuser  <= nxt.mode;
                s_tdata  <= nxt.value;
                s_tvalid <= 1'b1;
                words_offered++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Sink side: random backpressure plus one long stall that backs the block up.
    always @(negedge clk)
    begin : sink_drive
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && words_in >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct());
    end

    // Monitor: check the result word against the oldest prediction, then
    // predict for any request taken at this same edge.
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", {30'd0, m_tuser}, {30'd0, want.status});
                    if (m_tdata[31:0] !== want.popped)
                        report_mismatch("popped_value", m_tdata[31:0], want.popped);
                    if (m_tdata[39:32] !== want.lower)
                        report_mismatch("lower_count", {24'd0, m_tdata[39:32]},
                                        {24'd0, want.lower});
                    if (m_tdata[47:40] !== want.upper)
                        report_mismatch("upper_count", {24'd0, m_tdata[47:40]},
                                        {24'd0, want.upper});
                end
                words_out++;
            end
            if (s_tvalid && s_tready)
            begin
                outcome_q.push_back(stack_model_step(mode_t'(s_tuser), s_tdata));
                words_in++;
            end
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d of %0d words in, %0d results pending",
                 cycles, words_in, total_words, outcome_q.size());
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        request_t  rq;
        seg_kind_t kind;
        int        seg;
        int        seg_len;
        int        push_pct;
        int        upper_pct;
        int        n_rand;

        // directed: empty pops on both sides, corner values, LIFO order, drain to empty
        rq.value = $urandom; rq.mode = MODE_POP_LOWER;  request_q.push_back(rq);
        rq.value = $urandom; rq.mode = MODE_POP_UPPER;  request_q.push_back(rq);
        rq.mode = MODE_PUSH_LOWER;
        rq.value = 32'h7FFF_FFFF; request_q.push_back(rq);
        rq.value = 32'h8000_0000; request_q.push_back(rq);
        rq.value = 32'h0000_0000; request_q.push_back(rq);  // zero counts like any value
        rq.value = 32'hFFFF_FFFF; request_q.push_back(rq);
        rq.value = 32'hAAAA_AAAA; request_q.push_back(rq);
        rq.mode = MODE_PUSH_UPPER;
        rq.value = 32'hFFFF_FFFF; request_q.push_back(rq);
        rq.value = 32'h0000_0000; request_q.push_back(rq);
        rq.value = 32'h8000_0000; request_q.push_back(rq);
        rq.value = 32'h7FFF_FFFF; request_q.push_back(rq);
        rq.value = 32'h5555_5555; request_q.push_back(rq);
        for (int i = 0; i < 6; i++)
        begin
            rq.mode = MODE_POP_LOWER; rq.value = $urandom; request_q.push_back(rq);
        end
        for (int i = 0; i < 6; i++)
        begin
            rq.mode = MODE_POP_UPPER; rq.value = $urandom; request_q.push_back(rq);
        end

        // random: alternating fill / drain / mixed stretches so both full and
        // empty are hit repeatedly, with the split between stacks varying
        n_rand = 0;
        seg = 0;
        while (n_rand < RANDOM_WORDS)
        begin
            kind = seg_kind_t'(seg % 3);
            seg_len = $urandom_range(170, 260);
            push_pct = (kind == SEG_FILL) ? 85 : (kind == SEG_DRAIN) ? 15 : 50;
            upper_pct = $urandom_range(15, 85);
            for (int i = 0; i < seg_len && n_rand < RANDOM_WORDS; i++)
            begin
                if ($urandom_range(99) < push_pct)
                    rq.mode = ($urandom_range(99) < upper_pct) ? MODE_PUSH_UPPER
                                                              : MODE_PUSH_LOWER;
                else
                    rq.mode = ($urandom_range(99) < upper_pct) ? MODE_POP_UPPER
                                                              : MODE_POP_LOWER;
                rq.value = rand_word();
                request_q.push_back(rq);
                n_rand++;
            end
            seg++;
        end
        total_words = request_q.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(words_in == total_words && outcome_q.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests in %0d cycles: %0d pushes, %0d pops,",
                 words_in, cycles, n_push_done, n_pop_done);
        $display("%0d refused full, %0d refused empty, peak combined depth %0d of %0d slots",
                 n_full, n_empty, peak_held, DSSM_SLOTS);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
